FILE: src/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the environmental sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

    // Datapath widths
    localparam int CFG_W  = 64;
    localparam int COEF_W = 48;
    localparam int DIV_W  = 64;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TEMP    = 3'd0,
        CFG_PRESS_A = 3'd1,
        CFG_PRESS_B = 3'd2,
        CFG_PRESS_C = 3'd3,
        CFG_HUM     = 3'd4
    } t_cfg_idx;

    // Input transaction
    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } t_in_item;

    // Output transaction
    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic [16:0]        hum_q22_10;
    } t_out_item;

    // Finished results that ride alongside the pressure divider
    typedef struct packed {
        logic [31:0] temp_centi;
        logic [16:0] hum_q22_10;
    } t_side;

endpackage

FILE: src/env_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation_top
// Integer temperature, pressure and humidity compensation of one raw reading.
// ----------------------------------------------------------------------------
// Pipeline from input transaction to result: 15 front stages, 64 divider
// stages, 6 back stages.
// Throughput: one transaction per cycle; the 64-stage quotient pipeline sets
// the depth, and a stall on the output freezes all stages together.
// Reset clears all valid bits and the coefficient registers to zero.
// ----------------------------------------------------------------------------
module env_sensor_compensation_top
    import esc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    logic [COEF_W-1:0] r_cfg_t, r_cfg_pa, r_cfg_pb, r_cfg_pc;
    logic [CFG_W-1:0]  r_cfg_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_t  <= '0;
            r_cfg_pa <= '0;
            r_cfg_pb <= '0;
            r_cfg_pc <= '0;
            r_cfg_h  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEMP:    r_cfg_t  <= i_cfg_data[COEF_W-1:0];
                CFG_PRESS_A: r_cfg_pa <= i_cfg_data[COEF_W-1:0];
                CFG_PRESS_B: r_cfg_pb <= i_cfg_data[COEF_W-1:0];
                CFG_PRESS_C: r_cfg_pc <= i_cfg_data[COEF_W-1:0];
                CFG_HUM:     r_cfg_h  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack coefficients
    logic [15:0]        w_t1, w_p1;
    logic signed [31:0] w_t2, w_t3;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [7:0]         w_h1, w_h3;
    logic signed [31:0] w_h2, w_h5, w_h6;

    assign w_t1 = r_cfg_t[15:0];
    assign w_t2 = $signed({{16{r_cfg_t[31]}}, r_cfg_t[31:16]});
    assign w_t3 = $signed({{16{r_cfg_t[47]}}, r_cfg_t[47:32]});
    assign w_p1 = r_cfg_pa[15:0];
    assign w_p2 = $signed(r_cfg_pa[31:16]);
    assign w_p3 = $signed(r_cfg_pa[47:32]);
    assign w_p4 = $signed(r_cfg_pb[15:0]);
    assign w_p5 = $signed(r_cfg_pb[31:16]);
    assign w_p6 = $signed(r_cfg_pb[47:32]);
    assign w_p7 = $signed(r_cfg_pc[15:0]);
    assign w_p8 = $signed(r_cfg_pc[31:16]);
    assign w_p9 = $signed(r_cfg_pc[47:32]);
    assign w_h1 = r_cfg_h[7:0];
    assign w_h2 = $signed({{16{r_cfg_h[23]}}, r_cfg_h[23:8]});
    assign w_h3 = r_cfg_h[31:24];
    assign w_h5 = $signed({{20{r_cfg_h[55]}}, r_cfg_h[55:44]});
    assign w_h6 = $signed({{24{r_cfg_h[63]}}, r_cfg_h[63:56]});

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances when the output is free
    // ------------------------------------------------------------------
    logic        w_adv;
    logic [15:1] r_vld;
    logic [6:1]  r_pv;
    logic        w_dv_valid;

    assign w_adv       = !r_pv[6] || i_out_ready;
    assign o_in_ready  = w_adv;
    assign o_out_valid = r_pv[6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_pv  <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[14:1], i_in_valid};
            r_pv  <= {r_pv[5:1], w_dv_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offsets from raw readings
    // ------------------------------------------------------------------
    logic signed [31:0] n1_ta, n1_d, n1_xb;
    logic [20:0]        n1_pn;

    assign n1_ta = $signed({15'b0, i_in_data.raw_temp[19:3]}) - $signed({15'b0, w_t1, 1'b0});
    assign n1_d  = $signed({16'b0, i_in_data.raw_temp[19:4]}) - $signed({16'b0, w_t1});
    assign n1_pn = 21'd1048576 - {1'b0, i_in_data.raw_press};
    assign n1_xb = $signed({2'b0, i_in_data.raw_hum, 14'b0} - {r_cfg_h[43:32], 20'b0}
                           + 32'd16384);

    // Stage 2..4: fine temperature
    logic signed [31:0] r1_ta, r1_d, r2_ap, r2_dd, r3_a, r3_bp, r4_fine;
    // Raw pressure offset and humidity base carried forward
    logic [20:0]        r1_pn, r2_pn, r3_pn, r4_pn, r5_pn, r6_pn, r7_pn, r8_pn;
    logic signed [31:0] r1_xb, r2_xb, r3_xb, r4_xb, r5_xb, r6_xb;

    // Stage 5: temperature result and offsets of fine temperature
    logic signed [31:0] n5_temp, n5_h, r5_h;
    logic signed [33:0] n5_va, r5_va;

    assign n5_temp = (r4_fine * 32'sd5 + 32'sd128) >>> 8;
    assign n5_va   = $signed({{2{r4_fine[31]}}, r4_fine}) - 34'sd128000;
    assign n5_h    = r4_fine - 32'sd76800;

    // Temperature result delay line, stages 5..15
    logic [31:0] r_tdl [11];

    // ------------------------------------------------------------------
    // Pressure front end, stages 6..15
    // ------------------------------------------------------------------
    logic signed [63:0] r6_va2, r6_vp5, r6_vp2, r7_vp5, r7_vp2;
    logic signed [63:0] r7_m6lo, r7_m3lo;
    logic [31:0]        r7_m6hi, r7_m3hi;
    logic signed [63:0] r8_vb, r8_vaa, w8_va3;
    logic [47:0]        r9_ml;
    logic [31:0]        r9_mh;
    logic [63:0]        r9_num0;
    logic [63:0]        w10_dfull;
    logic signed [63:0] w10_dsh, r10_den, r11_den;
    logic [43:0]        r10_nl;
    logic [31:0]        r10_nh;
    logic [63:0]        r11_num;
    logic [63:0]        r12_un, r12_ud, r13_un, r13_ud, r14_un, r14_ud, r15_un, r15_ud;
    logic               r12_neg, r13_neg, r14_neg, r15_neg;

    assign w8_va3    = r7_m3lo + $signed({r7_m3hi, 32'b0});
    assign w10_dfull = {16'b0, r9_ml} + {r9_mh, 32'b0};
    assign w10_dsh   = $signed(w10_dfull) >>> 33;

    // ------------------------------------------------------------------
    // Humidity, stages 6..15
    // ------------------------------------------------------------------
    logic signed [31:0] r6_mh5, r6_mh6, r6_mh3;
    logic signed [31:0] r7_x, r7_ya, r7_yb, r8_x, r8_yp, r9_x, r9_y1;
    logic signed [31:0] r10_x, r10_ym, r11_x, r11_y, r12_hx;
    logic signed [31:0] w13_hs, r13_hss, r13_hx, r14_q, r14_hx, w15_hv;
    logic [31:0]        w15_hc;
    logic [16:0]        r15_hum;

    assign w13_hs = r12_hx >>> 15;
    assign w15_hv = r14_hx - (r14_q >>> 4);
    // Clamp to 0..100 %RH
    assign w15_hc = w15_hv[31] ? 32'd0 :
                    (w15_hv > 32'sd419430400) ? 32'd419430400 : w15_hv;

    // Front pipeline data registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // stage 1
            r1_ta <= n1_ta;
            r1_d  <= n1_d;
            r1_pn <= n1_pn;
            r1_xb <= n1_xb;
            // stage 2
            r2_ap <= r1_ta * w_t2;
            r2_dd <= r1_d * r1_d;
            r2_pn <= r1_pn;
            r2_xb <= r1_xb;
            // stage 3
            r3_a  <= r2_ap >>> 11;
            r3_bp <= (r2_dd >>> 12) * w_t3;
            r3_pn <= r2_pn;
            r3_xb <= r2_xb;
            // stage 4
            r4_fine <= r3_a + (r3_bp >>> 14);
            r4_pn   <= r3_pn;
            r4_xb   <= r3_xb;
            // stage 5
            r_tdl[0] <= n5_temp;
            r5_va    <= n5_va;
            r5_h     <= n5_h;
            r5_pn    <= r4_pn;
            r5_xb    <= r4_xb;
            // stage 6
            r6_va2 <= r5_va * r5_va;
            r6_vp5 <= r5_va * w_p5;
            r6_vp2 <= r5_va * w_p2;
            r6_mh5 <= w_h5 * r5_h;
            r6_mh6 <= r5_h * w_h6;
            r6_mh3 <= r5_h * $signed({24'b0, w_h3});
            r6_pn  <= r5_pn;
            r6_xb  <= r5_xb;
            // stage 7: split 64-bit products into 32-bit halves
            r7_m6lo <= $signed({1'b0, r6_va2[31:0]}) * w_p6;
            r7_m6hi <= r6_va2[63:32] * {{16{w_p6[15]}}, w_p6};
            r7_m3lo <= $signed({1'b0, r6_va2[31:0]}) * w_p3;
            r7_m3hi <= r6_va2[63:32] * {{16{w_p3[15]}}, w_p3};
            r7_vp5  <= r6_vp5;
            r7_vp2  <= r6_vp2;
            r7_pn   <= r6_pn;
            r7_x    <= (r6_xb - r6_mh5) >>> 15;
            r7_ya   <= r6_mh6 >>> 10;
            r7_yb   <= (r6_mh3 >>> 11) + 32'sd32768;
            // stage 8
            r8_vb  <= r7_m6lo + $signed({r7_m6hi, 32'b0}) + (r7_vp5 <<< 17)
                      + $signed({{13{w_p4[15]}}, w_p4, 35'b0});
            r8_vaa <= (w8_va3 >>> 8) + (r7_vp2 <<< 12);
            r8_pn  <= r7_pn;
            r8_yp  <= r7_ya * r7_yb;
            r8_x   <= r7_x;
            // stage 9
            r9_ml   <= r8_vaa[31:0] * w_p1;
            r9_mh   <= (r8_vaa[63:32] + 32'h0000_8000) * {16'b0, w_p1};
            r9_num0 <= {12'b0, r8_pn, 31'b0} - r8_vb;
            r9_y1   <= (r8_yp >>> 10) + 32'sd2097152;
            r9_x    <= r8_x;
            // stage 10: divisor, forced to one when zero
            r10_den <= (w10_dsh == 64'sd0) ? 64'sd1 : w10_dsh;
            r10_nl  <= r9_num0[31:0] * 12'd3125;
            r10_nh  <= r9_num0[63:32] * 32'd3125;
            r10_ym  <= r9_y1 * w_h2;
            r10_x   <= r9_x;
            // stage 11
            r11_num <= {20'b0, r10_nl} + {r10_nh, 32'b0};
            r11_den <= r10_den;
            r11_y   <= (r10_ym + 32'sd8192) >>> 14;
            r11_x   <= r10_x;
            // stage 12: magnitudes and quotient sign
            r12_un  <= r11_num[63] ? (64'd0 - r11_num) : r11_num;
            r12_ud  <= r11_den[63] ? (64'd0 - r11_den) : r11_den;
            r12_neg <= r11_num[63] ^ r11_den[63];
            r12_hx  <= r11_x * r11_y;
            // stage 13
            r13_un  <= r12_un;
            r13_ud  <= r12_ud;
            r13_neg <= r12_neg;
            r13_hss <= w13_hs * w13_hs;
            r13_hx  <= r12_hx;
            // stage 14
            r14_un  <= r13_un;
            r14_ud  <= r13_ud;
            r14_neg <= r13_neg;
            r14_q   <= (r13_hss >>> 7) * $signed({24'b0, w_h1});
            r14_hx  <= r13_hx;
            // stage 15
            r15_un  <= r14_un;
            r15_ud  <= r14_ud;
            r15_neg <= r14_neg;
            r15_hum <= w15_hc[28:12];
            // temperature delay
            for (int i = 1; i < 11; i++) begin
                r_tdl[i] <= r_tdl[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Pressure division
    // ------------------------------------------------------------------
    t_side       w_side_in, w_dv_side;
    logic [63:0] w_dv_quot;
    logic        w_dv_neg;

    assign w_side_in.temp_centi = r_tdl[10];
    assign w_side_in.hum_q22_10 = r15_hum;

    esc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_vld[15]),
        .i_num   (r15_un),
        .i_den   (r15_ud),
        .i_neg   (r15_neg),
        .i_side  (w_side_in),
        .o_valid (w_dv_valid),
        .o_quot  (w_dv_quot),
        .o_neg   (w_dv_neg),
        .o_side  (w_dv_side)
    );

    // ------------------------------------------------------------------
    // Pressure back end, stages P1..P6
    // ------------------------------------------------------------------
    logic signed [63:0] r_p1_p, w_p2_s, r_p2_p, r_p2_s, r_p2_tlo, r_p2_ulo;
    logic [31:0]        r_p2_thi, r_p2_uhi;
    logic signed [63:0] r_p3_p, r_p3_s, r_p3_t, r_p3_vb, w_p3_u;
    logic [63:0]        r_p4_ll;
    logic [31:0]        r_p4_lh, r_p4_hl;
    logic signed [63:0] r_p4_p, r_p4_vb, r_p5_p, r_p5_va, r_p5_vb, w_p6_pf;
    t_side              r_sdl [5];
    t_out_item          r_out;

    assign w_p2_s = r_p1_p >>> 13;
    assign w_p3_u = r_p2_ulo + $signed({r_p2_uhi, 32'b0});
    assign w_p6_pf = ($signed(r_p5_p + r_p5_va + r_p5_vb) >>> 8)
                     + $signed({{44{w_p7[15]}}, w_p7, 4'b0});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // P1: apply quotient sign
            r_p1_p   <= w_dv_neg ? $signed(64'd0 - w_dv_quot) : $signed(w_dv_quot);
            r_sdl[0] <= w_dv_side;
            // P2
            r_p2_tlo <= $signed({1'b0, w_p2_s[31:0]}) * w_p9;
            r_p2_thi <= w_p2_s[63:32] * {{16{w_p9[15]}}, w_p9};
            r_p2_ulo <= $signed({1'b0, r_p1_p[31:0]}) * w_p8;
            r_p2_uhi <= r_p1_p[63:32] * {{16{w_p8[15]}}, w_p8};
            r_p2_p   <= r_p1_p;
            r_p2_s   <= w_p2_s;
            r_sdl[1] <= r_sdl[0];
            // P3
            r_p3_t   <= r_p2_tlo + $signed({r_p2_thi, 32'b0});
            r_p3_vb  <= w_p3_u >>> 19;
            r_p3_p   <= r_p2_p;
            r_p3_s   <= r_p2_s;
            r_sdl[2] <= r_sdl[1];
            // P4: 64x64 product kept to its low 64 bits
            r_p4_ll  <= {32'b0, r_p3_t[31:0]} * {32'b0, r_p3_s[31:0]};
            r_p4_lh  <= r_p3_t[31:0] * r_p3_s[63:32];
            r_p4_hl  <= r_p3_t[63:32] * r_p3_s[31:0];
            r_p4_p   <= r_p3_p;
            r_p4_vb  <= r_p3_vb;
            r_sdl[3] <= r_sdl[2];
            // P5
            r_p5_va  <= $signed(r_p4_ll + {r_p4_lh + r_p4_hl, 32'b0}) >>> 25;
            r_p5_p   <= r_p4_p;
            r_p5_vb  <= r_p4_vb;
            r_sdl[4] <= r_sdl[3];
            // P6: output register
            r_out.temp_centi  <= $signed(r_sdl[4].temp_centi);
            r_out.press_q24_8 <= w_p6_pf[31:0];
            r_out.hum_q22_10  <= r_sdl[4].hum_q22_10;
        end
    end

    assign o_out_data = r_out;

endmodule

FILE: src/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sign flag and finished side results carried along each stage.
// ----------------------------------------------------------------------------
module esc_div
    import esc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DIV_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    input  logic             i_neg,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [DIV_W-1:0] o_quot,
    output logic             o_neg,
    output t_side            o_side
);

    logic [DIV_W-1:0] r_rem  [DIV_W];
    logic [DIV_W-1:0] r_num  [DIV_W];
    logic [DIV_W-1:0] r_quo  [DIV_W];
    logic [DIV_W-1:0] r_den  [DIV_W];
    logic             r_neg  [DIV_W];
    t_side            r_side [DIV_W];
    logic [DIV_W-1:0] r_vld;

    for (genvar k = 0; k < DIV_W; k++) begin : g_step
        logic [DIV_W-1:0] w_rem, w_num, w_quo, w_den;
        logic             w_neg, w_vld;
        t_side            w_side;
        logic [DIV_W:0]   w_trial, w_diff;
        logic [DIV_W-1:0] n_rem, n_quo;

        // Select the stage input
        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_num  = i_num;
            assign w_quo  = '0;
            assign w_den  = i_den;
            assign w_neg  = i_neg;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_num  = r_num[k-1];
            assign w_quo  = r_quo[k-1];
            assign w_den  = r_den[k-1];
            assign w_neg  = r_neg[k-1];
            assign w_side = r_side[k-1];
            assign w_vld  = r_vld[k-1];
        end

        // Shift in one numerator bit, subtract when it fits
        assign w_trial = {w_rem, w_num[DIV_W-1]};
        assign w_diff  = w_trial - {1'b0, w_den};
        assign n_rem   = w_diff[DIV_W] ? w_trial[DIV_W-1:0] : w_diff[DIV_W-1:0];
        assign n_quo   = {w_quo[DIV_W-2:0], ~w_diff[DIV_W]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_num[k]  <= {w_num[DIV_W-2:0], 1'b0};
                r_quo[k]  <= n_quo;
                r_den[k]  <= w_den;
                r_neg[k]  <= w_neg;
                r_side[k] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end
    end

    assign o_valid = r_vld[DIV_W-1];
    assign o_quot  = r_quo[DIV_W-1];
    assign o_neg   = r_neg[DIV_W-1];
    assign o_side  = r_side[DIV_W-1];

endmodule
